// ===== rtl/core/rkc_pkg.sv =====
// ----------------------------------------------------------------------------
// rkc_pkg
// Shared constants, register indexes and helpers for the RGB kernel
// convolution block.
// ----------------------------------------------------------------------------
package rkc_pkg;

    // Defaults for the top-level parameters
    localparam int KERNEL_SIZE_DEF = 5;
    localparam int MAX_WIDTH_DEF   = 2048;

    // Fixed field and register widths
    localparam int CFG_W      = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int KROWS      = 5;
    localparam int ROW_W      = 13;
    localparam int MAX_HEIGHT = 4096;
    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int ACC_W      = 24;
    localparam int FAC_W      = 16;
    localparam int SAT_MAX    = 255;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KROW0  = 3'd0,
        REG_KROW1  = 3'd1,
        REG_KROW2  = 3'd2,
        REG_KROW3  = 3'd3,
        REG_KROW4  = 3'd4,
        REG_WIDTH  = 3'd5,
        REG_HEIGHT = 3'd6
    } t_reg_idx;

    // Input word kinds
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef logic [KROWS-1:0][CFG_W-1:0] t_kernel;

    // Fetch one signed coefficient; positions off the 5x5 grid weigh zero
    function automatic logic signed [CH_W-1:0] coef_at(input t_kernel rows,
                                                       input int ky, input int kx);
        logic signed [CH_W-1:0] k;
        k = '0;
        if (ky >= 0 && ky < KROWS && kx >= 0 && kx < KROWS) begin
            k = rows[3'(ky)][CH_W*kx +: CH_W];
        end
        return k;
    endfunction

endpackage

// ===== rtl/core/rkc_div.sv =====
// ----------------------------------------------------------------------------
// rkc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rkc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rkc_pkg::ACC_W-1:0]  i_dividend,
    input  logic [rkc_pkg::ACC_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [rkc_pkg::ACC_W-1:0]  o_quotient
);
    localparam int W   = rkc_pkg::ACC_W;
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     r_rem, r_quo, r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [W:0]       trial;
    logic             ge;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        trial = {r_rem, r_quo[W-1]};
        ge    = trial >= {1'b0, r_div};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? W'(trial - {1'b0, r_div}) : W'(trial);
            r_quo <= {r_quo[W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/core/rgb_kernel_convolution.sv =====
// ----------------------------------------------------------------------------
// rgb_kernel_convolution
// Normalised KxK convolution over a raster stream of 24-bit pixels.
// ----------------------------------------------------------------------------
// Each pixel word is written into a line store of 2^ceil(log2(3*RAD+1))
// lines. Once more than RAD*width+RAD pixels are pending, the block reads
// the KxK neighbourhood of the next output pixel from that single-port-read
// memory, one tap per cycle, with edge pixels replicated. It accumulates all
// three channels and the coefficient total, then divides each sum by the
// total in bit-serial dividers, one per channel, and saturates to 0..255.
// An item that gives a result keeps the block from taking a new word
// through the tap walk, the divide and the output hand-off, longer while
// the output word waits; an item that gives none leaves it ready for the
// next word. Flush words drain the remaining outputs after the last pixel
// of a frame; tlast marks the last output pixel. Writing the width or
// height abandons the frame in progress. No clearing pass is needed.
// ----------------------------------------------------------------------------
module rgb_kernel_convolution #(
    parameter int KERNEL_SIZE = rkc_pkg::KERNEL_SIZE_DEF,
    parameter int MAX_WIDTH   = rkc_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [rkc_pkg::PIX_W-1:0]     i_s_axis_tdata,  // channel_0, channel_1, channel_2
    input  logic                          i_s_axis_tuser,  // op
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [rkc_pkg::PIX_W-1:0]     o_m_axis_tdata,  // out_channel_0, _1, _2
    output logic                          o_m_axis_tlast,  // frame_end
    input  logic                          i_cfg_we,
    input  logic [rkc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rkc_pkg::CFG_W-1:0]     i_cfg_data
);
    localparam int RAD   = KERNEL_SIZE / 2;
    localparam int TAP_W = $clog2(KERNEL_SIZE);
    localparam int CB    = $clog2(MAX_WIDTH);
    localparam int COL_W = CB + 1;
    localparam int LB    = $clog2(3 * RAD + 1);
    localparam int AW    = LB + CB;
    localparam int ROW_W = rkc_pkg::ROW_W;
    localparam int PW    = COL_W + ROW_W;
    localparam int ACC_W = rkc_pkg::ACC_W;
    localparam int FAC_W = rkc_pkg::FAC_W;
    localparam int CH_W  = rkc_pkg::CH_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MAC  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    // Configuration
    rkc_pkg::t_kernel   r_kern;
    logic [COL_W-1:0]   r_w;
    logic [ROW_W-1:0]   r_h;
    logic [PW-1:0]      frame_total, lag;

    // Frame position
    logic [COL_W-1:0]   r_in_col, r_out_col, n_in_col, n_out_col, cur_col;
    logic [ROW_W-1:0]   r_in_row, r_out_row, n_in_row, n_out_row, cur_row;
    logic [PW-1:0]      r_pend, n_pend;
    logic               r_in_done, n_in_done;

    // Sequencer and datapath
    t_state             r_state;
    logic [COL_W-1:0]   r_cur_col;
    logic [ROW_W-1:0]   r_cur_row;
    logic               r_last, frame_end;
    logic [TAP_W-1:0]   r_ti, r_tj;
    logic               r_issue, r_pv;
    logic signed [CH_W-1:0]  r_pk, tap_k;
    logic signed [ACC_W-1:0] r_acc [3];
    logic signed [FAC_W-1:0] r_fac, fac_eff;
    logic [2:0]         r_neg;
    logic [ACC_W-1:0]   mag_s [3];
    logic [ACC_W-1:0]   quo [3];
    logic [2:0]         div_done;
    logic               div_start;
    logic [rkc_pkg::PIX_W-1:0] r_res;

    // Line store
    logic [rkc_pkg::PIX_W-1:0] mem [2**AW];
    logic [rkc_pkg::PIX_W-1:0] r_rd_data;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic               mem_we, s_acc, emit;

    // Output register
    logic               r_o_valid, r_o_last;
    logic [rkc_pkg::PIX_W-1:0] r_o_data;

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    // Work out position updates for an accepted word
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_pend    = r_pend;
        n_in_done = r_in_done;
        emit      = 1'b0;
        mem_we    = 1'b0;
        frame_end = 1'b0;
        wr_addr   = '0;
        cur_col   = r_out_col;
        cur_row   = r_out_row;
        if (s_acc) begin
            if (i_s_axis_tuser == rkc_pkg::OP_PIXEL) begin
                // A pixel after a complete frame starts a new one
                if (r_in_done) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                    n_pend    = '0;
                    n_in_done = 1'b0;
                end
                mem_we  = 1'b1;
                wr_addr = {n_in_row[LB-1:0], n_in_col[CB-1:0]};
                if (n_in_col + 1'b1 >= r_w) begin
                    n_in_col = '0;
                    n_in_row = n_in_row + 1'b1;
                    if (n_in_row >= r_h) begin
                        n_in_done = 1'b1;
                    end
                end else begin
                    n_in_col = n_in_col + 1'b1;
                end
                n_pend = n_pend + 1'b1;
                emit   = n_pend > lag;
            end else begin
                emit = r_in_done && (r_pend != '0);
            end
            if (emit) begin
                cur_col   = n_out_col;
                cur_row   = n_out_row;
                frame_end = (n_out_row == r_h - 1'b1) && (n_out_col == r_w - 1'b1);
                if (n_out_col + 1'b1 >= r_w) begin
                    n_out_col = '0;
                    n_out_row = n_out_row + 1'b1;
                end else begin
                    n_out_col = n_out_col + 1'b1;
                end
                n_pend = n_pend - 1'b1;
                if (frame_end) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                    n_pend    = '0;
                    n_in_done = 1'b0;
                end
            end
        end
    end

    // Tap address with edge replication, and its coefficient
    always_comb begin
        int rr, cc;
        rr = int'(r_cur_row) + int'(r_ti) - RAD;
        cc = int'(r_cur_col) + int'(r_tj) - RAD;
        if (rr < 0) rr = 0;
        if (rr > int'(r_h) - 1) rr = int'(r_h) - 1;
        if (cc < 0) cc = 0;
        if (cc > int'(r_w) - 1) cc = int'(r_w) - 1;
        rd_addr = {LB'(rr), CB'(cc)};
        tap_k   = rkc_pkg::coef_at(r_kern, int'(r_ti) + 2 - RAD, int'(r_tj) + 2 - RAD);
    end

    // Line store: written only while idle; read every cycle, the data used only while accumulating
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= {i_s_axis_tdata};
        end
        r_rd_data <= mem[rd_addr];
    end

    // Geometry derived values, valid in the cycle after a write
    always_comb begin
        frame_total = PW'(r_w) * PW'(r_h);
        lag         = PW'(RAD) * PW'(r_w) + PW'(RAD);
    end

    // Configuration and frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kern    <= {rkc_pkg::CFG_W'(0), rkc_pkg::CFG_W'(0), rkc_pkg::CFG_W'(65536),
                          rkc_pkg::CFG_W'(0), rkc_pkg::CFG_W'(0)};
            r_w       <= COL_W'(MAX_WIDTH);
            r_h       <= ROW_W'(rkc_pkg::MAX_HEIGHT);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pend    <= '0;
            r_in_done <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rkc_pkg::REG_KROW0, rkc_pkg::REG_KROW1, rkc_pkg::REG_KROW2,
                rkc_pkg::REG_KROW3, rkc_pkg::REG_KROW4: begin
                    r_kern[i_cfg_idx] <= i_cfg_data;
                end
                rkc_pkg::REG_WIDTH: begin
                    if (i_cfg_data[11:0] == '0) begin
                        r_w <= COL_W'(1);
                    end else if (int'(i_cfg_data[11:0]) > MAX_WIDTH) begin
                        r_w <= COL_W'(MAX_WIDTH);
                    end else begin
                        r_w <= COL_W'(i_cfg_data[11:0]);
                    end
                end
                rkc_pkg::REG_HEIGHT: begin
                    if (i_cfg_data[12:0] == '0) begin
                        r_h <= ROW_W'(1);
                    end else if (int'(i_cfg_data[12:0]) > rkc_pkg::MAX_HEIGHT) begin
                        r_h <= ROW_W'(rkc_pkg::MAX_HEIGHT);
                    end else begin
                        r_h <= i_cfg_data[12:0];
                    end
                end
                default: begin
                end
            endcase
            // Geometry writes abandon the frame
            if (i_cfg_idx == rkc_pkg::REG_WIDTH || i_cfg_idx == rkc_pkg::REG_HEIGHT) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                r_pend    <= '0;
                r_in_done <= 1'b0;
            end
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_pend    <= n_pend;
            r_in_done <= n_in_done;
        end
    end

    // Division operands
    always_comb begin
        fac_eff = (r_fac == '0) ? FAC_W'(1) : r_fac;
        for (int c = 0; c < 3; c++) begin
            mag_s[c] = r_acc[c][ACC_W-1] ? ACC_W'(-r_acc[c]) : ACC_W'(r_acc[c]);
        end
    end

    assign div_start = (r_state == S_MAC) && !r_issue && !r_pv;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_issue <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (emit) begin
                        r_state <= S_MAC;
                        r_issue <= 1'b1;
                        r_pv    <= 1'b0;
                    end
                end
                S_MAC: begin
                    r_pv <= r_issue;
                    if (r_issue && r_tj == TAP_W'(KERNEL_SIZE - 1)
                        && r_ti == TAP_W'(KERNEL_SIZE - 1)) begin
                        r_issue <= 1'b0;
                    end
                    if (div_start) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done[0]) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_o_valid || i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Tap walk and accumulation
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_ti  <= '0;
            r_tj  <= '0;
            r_fac <= '0;
            for (int c = 0; c < 3; c++) begin
                r_acc[c] <= '0;
            end
            if (emit) begin
                r_cur_col <= cur_col;
                r_cur_row <= cur_row;
                r_last    <= frame_end;
            end
        end else if (r_state == S_MAC) begin
            r_pk <= tap_k;
            if (r_issue) begin
                if (r_tj == TAP_W'(KERNEL_SIZE - 1)) begin
                    r_tj <= '0;
                    r_ti <= r_ti + 1'b1;
                end else begin
                    r_tj <= r_tj + 1'b1;
                end
            end
            if (r_pv) begin
                for (int c = 0; c < 3; c++) begin
                    r_acc[c] <= r_acc[c] + ACC_W'($signed({1'b0, r_rd_data[CH_W*c +: CH_W]})
                                                  * r_pk);
                end
                r_fac <= r_fac + FAC_W'(r_pk);
            end
            // Quotient is non-negative only when signs agree
            if (div_start) begin
                for (int c = 0; c < 3; c++) begin
                    r_neg[c] <= r_acc[c][ACC_W-1] != fac_eff[FAC_W-1];
                end
            end
        end
    end

    // Dividers, one per channel
    for (genvar g = 0; g < 3; g++) begin : g_div
        rkc_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (div_start),
            .i_dividend (mag_s[g]),
            .i_divisor  (ACC_W'(fac_eff[FAC_W-1] ? -fac_eff : fac_eff)),
            .o_done     (div_done[g]),
            .o_quotient (quo[g])
        );
    end

    // Saturate quotients, negative results to zero
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && div_done[0]) begin
            for (int c = 0; c < 3; c++) begin
                if (r_neg[c]) begin
                    r_res[CH_W*c +: CH_W] <= '0;
                end else if (quo[c] > ACC_W'(rkc_pkg::SAT_MAX)) begin
                    r_res[CH_W*c +: CH_W] <= CH_W'(rkc_pkg::SAT_MAX);
                end else begin
                    r_res[CH_W*c +: CH_W] <= quo[c][CH_W-1:0];
                end
            end
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_OUT && (!r_o_valid || i_m_axis_tready)) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_o_valid || i_m_axis_tready)) begin
            r_o_data <= r_res;
            r_o_last <= r_last;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tlast  = r_o_last;

    // Line store is only written while no neighbourhood is being read
    a_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_state == S_IDLE)
        else $error("line store written during accumulation");

    // Pending pixels never exceed a frame
    a_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= frame_total)
        else $error("pending count beyond frame size");

    // Dividers finish only while the sequencer waits for them
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done[0] |-> r_state == S_DIV)
        else $error("divider finished outside divide phase");

endmodule

// ===== bench/rgb_kernel_convolution_tb.sv =====
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_tb
// Self-checking bench for the normalised 5x5 RGB convolution block.
// ----------------------------------------------------------------------------
// Pixel and flush words go in on the slave stream. Each accepted word runs
// through a bench-side model of the line store, edge replication, divide and
// saturation. Filtered words and frame ends are then checked in order on the
// master stream. Directed frames cover extreme kernels, clamped geometry and
// divisor-zero kernels. Random frames follow under varying idle and stall
// patterns, with early new frames, abandoned frames and a long output stall.
// ----------------------------------------------------------------------------
module rgb_kernel_convolution_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   LINE_SLOTS   = 10;
    localparam int   MAXW         = 2048;
    localparam int   SETTLE       = 60;
    localparam int   STALL_LIMIT  = 5000;
    localparam logic [rkc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [rkc_pkg::CH_W-1:0] ch [3];
        logic                     last;
    } t_pix_out;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [rkc_pkg::PIX_W-1:0]     i_s_axis_tdata = '0;
    logic                          i_s_axis_tuser = 1'b0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    logic [rkc_pkg::PIX_W-1:0]     o_m_axis_tdata;
    logic                          o_m_axis_tlast;
    logic                          i_cfg_we = 1'b0;
    logic [rkc_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [rkc_pkg::CFG_W-1:0]     i_cfg_data = '0;

    rgb_kernel_convolution dut (.*);

    always #5 i_clk = ~i_clk;

    // Bench copy of the filter state
    logic [rkc_pkg::PIX_W-1:0] pix_lines [LINE_SLOTS][MAXW];
    logic [rkc_pkg::CFG_W-1:0] krow [rkc_pkg::KROWS];
    int unsigned      width_reg, height_reg;
    int               in_col, in_row, out_col, out_row;
    bit               frame_in;
    t_pix_out         pending_pix [$];

    int  n_errors, n_words, n_pixels, n_flushes, n_results, n_frames;
    int  src_idle_pct, snk_stall_pct, hold_off, quiet_cycles;

    function automatic int eff_width();
        if (width_reg < 1) return 1;
        if (width_reg > MAXW) return MAXW;
        return width_reg;
    endfunction

    function automatic int eff_height();
        if (height_reg < 1) return 1;
        if (height_reg > rkc_pkg::MAX_HEIGHT) return rkc_pkg::MAX_HEIGHT;
        return height_reg;
    endfunction

    function automatic void restart_frame();
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        frame_in = 1'b0;
    endfunction

    function automatic logic [rkc_pkg::CH_W-1:0] clip_byte(input int acc, input int div);
        int q;
        q = acc / div;
        if (q < 0) q = 0;
        if (q > rkc_pkg::SAT_MAX) q = rkc_pkg::SAT_MAX;
        return q[rkc_pkg::CH_W-1:0];
    endfunction

    // Weighted sum over the clamped 5x5 window around the next output pixel
    function automatic t_pix_out filter_pixel(input int w, input int h);
        t_pix_out r;
        int acc [3];
        int div, ry, cx, k;
        logic [rkc_pkg::PIX_W-1:0] p;
        acc = '{0, 0, 0};
        div = 0;
        for (int dy = -2; dy <= 2; dy++) begin
            ry = out_row + dy;
            if (ry < 0) ry = 0;
            if (ry > h - 1) ry = h - 1;
            for (int dx = -2; dx <= 2; dx++) begin
                cx = out_col + dx;
                if (cx < 0) cx = 0;
                if (cx > w - 1) cx = w - 1;
                k = $signed(krow[dy+2][8*(dx+2) +: 8]);
                p = pix_lines[ry % LINE_SLOTS][cx];
                for (int c = 0; c < 3; c++) acc[c] += int'(p[8*c +: 8]) * k;
                div += k;
            end
        end
        if (div == 0) div = 1;
        for (int c = 0; c < 3; c++) r.ch[c] = clip_byte(acc[c], div);
        return r;
    endfunction

    // Advance the model by one accepted word
    function automatic void predict_word(input logic op,
                                         input logic [rkc_pkg::PIX_W-1:0] pix);
        int w, h, n_in, n_out;
        bit emit;
        t_pix_out r;
        w = eff_width();
        h = eff_height();
        if (op == rkc_pkg::OP_PIXEL) begin
            if (frame_in) restart_frame();
            pix_lines[in_row % LINE_SLOTS][in_col] = pix;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
                if (in_row >= h) frame_in = 1'b1;
            end
            n_in  = frame_in ? w * h : in_row * w + in_col;
            n_out = out_row * w + out_col;
            emit  = (n_in - n_out) > (2 * w + 2);
        end else begin
            n_out = out_row * w + out_col;
            emit  = frame_in && n_out < w * h;
        end
        if (!emit) return;
        r = filter_pixel(w, h);
        r.last = (n_out == w * h - 1);
        pending_pix.push_back(r);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        if (r.last) restart_frame();
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    endtask

    // Write one register, then leave the port idle before returning
    task automatic cfg_write(input logic [rkc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rkc_pkg::CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < rkc_pkg::KROWS) krow[idx] = val;
        else if (idx == rkc_pkg::REG_WIDTH) begin
            width_reg = val[11:0];
            restart_frame();
        end else if (idx == rkc_pkg::REG_HEIGHT) begin
            height_reg = val[12:0];
            restart_frame();
        end
        @(posedge i_clk);
    endtask

    // Offer one word and hold it until taken, then maybe idle
    task automatic send_word(input logic op, input logic [rkc_pkg::PIX_W-1:0] pix);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= pix;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_word(op, pix);
        n_words++;
        if (op == rkc_pkg::OP_PIXEL) n_pixels++; else n_flushes++;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every expected word has come out
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_pix.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_kernel(input logic [rkc_pkg::CFG_W-1:0] k [rkc_pkg::KROWS]);
        for (int r = 0; r < rkc_pkg::KROWS; r++) cfg_write(rkc_pkg::t_reg_idx'(r), k[r]);
    endtask

    function automatic logic [rkc_pkg::CFG_W-1:0] random_krow();
        logic [rkc_pkg::CFG_W-1:0] v;
        for (int c = 0; c < 5; c++) begin
            case ($urandom_range(3))
                0: v[8*c +: 8] = 8'($urandom);
                1: v[8*c +: 8] = 8'($urandom_range(4));
                2: v[8*c +: 8] = 8'(-$signed(8'($urandom_range(3))));
                default: v[8*c +: 8] = '0;
            endcase
        end
        return v;
    endfunction

    // One frame of pixels, then flushes; may break off or start early
    task automatic run_frame(input bit allow_break);
        int total;
        total = eff_width() * eff_height();
        for (int i = 0; i < total; i++) begin
            if ($urandom_range(99) < 8)
                send_word(rkc_pkg::OP_FLUSH, rkc_pkg::PIX_W'($urandom));
            if (allow_break && $urandom_range(999) < 8) return;
            send_word(rkc_pkg::OP_PIXEL, rkc_pkg::PIX_W'($urandom));
        end
        while (frame_in) begin
            if ($urandom_range(99) < 3) return;
            send_word(rkc_pkg::OP_FLUSH, rkc_pkg::PIX_W'($urandom));
        end
        n_frames++;
    endtask

    task automatic test_directed();
        logic [rkc_pkg::CFG_W-1:0] neg [rkc_pkg::KROWS] = '{default: 40'h8080808080};
        logic [rkc_pkg::CFG_W-1:0] zsum [rkc_pkg::KROWS];
        // Words at reset geometry, before any write: no output yet
        send_word(rkc_pkg::OP_PIXEL, 24'hFF00FF);
        send_word(rkc_pkg::OP_FLUSH, 24'h000000);
        drain();
        // Clamped geometry: zero width and height give a 1x1 frame
        cfg_write(rkc_pkg::REG_WIDTH, '0);
        cfg_write(rkc_pkg::REG_HEIGHT, '0);
        send_word(rkc_pkg::OP_PIXEL, 24'h80FF00);
        send_word(rkc_pkg::OP_FLUSH, 24'hFFFFFF);
        drain();
        // Most negative kernel on a 3x2 frame with extreme pixels
        cfg_write(rkc_pkg::REG_WIDTH, 40'd3);
        cfg_write(rkc_pkg::REG_HEIGHT, 40'd2);
        load_kernel(neg);
        send_word(rkc_pkg::OP_PIXEL, 24'h000000);
        send_word(rkc_pkg::OP_FLUSH, 24'h123456);
        send_word(rkc_pkg::OP_PIXEL, 24'hFFFFFF);
        send_word(rkc_pkg::OP_PIXEL, 24'hFF0000);
        send_word(rkc_pkg::OP_PIXEL, 24'h00FF00);
        send_word(rkc_pkg::OP_PIXEL, 24'h0000FF);
        send_word(rkc_pkg::OP_PIXEL, 24'hAA55AA);
        repeat (7) send_word(rkc_pkg::OP_FLUSH, 24'h000000);
        drain();
        // Zero coefficient total: divide by one, positive and negative sums
        zsum = '{40'h0000000000, 40'h0000010000, 40'h0001FE0100,
                 40'h0000FF0000, 40'h7F000000_81};
        load_kernel(zsum);
        cfg_write(REG_UNUSED, '1);
        cfg_write(rkc_pkg::REG_WIDTH, 40'hFFF);
        cfg_write(rkc_pkg::REG_WIDTH, 40'd2);
        cfg_write(rkc_pkg::REG_HEIGHT, 40'd3);
        for (int i = 0; i < 6; i++) send_word(rkc_pkg::OP_PIXEL, rkc_pkg::PIX_W'($urandom));
        while (frame_in) send_word(rkc_pkg::OP_FLUSH, '0);
        drain();
    endtask

    // Geometry extremes: the tallest and the widest frame, both abandoned
    task automatic test_extremes();
        logic [rkc_pkg::CFG_W-1:0] k [rkc_pkg::KROWS];
        for (int r = 0; r < rkc_pkg::KROWS; r++) k[r] = random_krow();
        load_kernel(k);
        cfg_write(rkc_pkg::REG_WIDTH, 40'd1);
        cfg_write(rkc_pkg::REG_HEIGHT, 40'd4096);
        for (int i = 0; i < 40; i++) send_word(rkc_pkg::OP_PIXEL, rkc_pkg::PIX_W'($urandom));
        drain();
        cfg_write(rkc_pkg::REG_WIDTH, 40'd2048);
        cfg_write(rkc_pkg::REG_HEIGHT, 40'd1);
        for (int i = 0; i < 120; i++) send_word(rkc_pkg::OP_PIXEL, rkc_pkg::PIX_W'($urandom));
        drain();
    endtask

    task automatic test_random(input int src_pct, input int snk_pct, input int target);
        int stop_at;
        logic [rkc_pkg::CFG_W-1:0] k [rkc_pkg::KROWS];
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        stop_at = n_words + target;
        while (n_words < stop_at) begin
            drain();
            for (int r = 0; r < rkc_pkg::KROWS; r++) k[r] = random_krow();
            load_kernel(k);
            cfg_write(rkc_pkg::REG_WIDTH, 40'($urandom_range(1, 8)));
            cfg_write(rkc_pkg::REG_HEIGHT, 40'($urandom_range(1, 6)));
            repeat ($urandom_range(1, 3)) run_frame(1'b1);
        end
        drain();
    endtask

    // Hold the output off while input keeps coming, so the block backs up
    task automatic test_backpressure();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        cfg_write(rkc_pkg::REG_WIDTH, 40'd8);
        cfg_write(rkc_pkg::REG_HEIGHT, 40'd6);
        hold_off = 400;
        run_frame(1'b0);
        drain();
    endtask

    // Output side: check each word, stall at random or for a held stretch
    always @(posedge i_clk) begin
        t_pix_out e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_results++;
            if (pending_pix.size() == 0) begin
                report_mismatch("unexpected word", o_m_axis_tdata, 0);
            end else begin
                e = pending_pix.pop_front();
                for (int c = 0; c < 3; c++)
                    if (o_m_axis_tdata[8*c +: 8] !== e.ch[c])
                        report_mismatch($sformatf("channel %0d", c),
                                        o_m_axis_tdata[8*c +: 8], e.ch[c]);
                if (o_m_axis_tlast !== e.last)
                    report_mismatch("frame end", o_m_axis_tlast, e.last);
            end
        end
        if (hold_off > 0) begin
            hold_off--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Watchdog on cycles with no word moving and no register write
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || i_cfg_we || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("rgb_kernel_convolution verification failed");
            $finish;
        end
    end

    initial begin
        n_errors = 0; n_words = 0; n_pixels = 0; n_flushes = 0;
        n_results = 0; n_frames = 0; quiet_cycles = 0;
        src_idle_pct = 0; snk_stall_pct = 0; hold_off = 0;
        krow = '{40'h0, 40'h0, 40'h10000, 40'h0, 40'h0};
        width_reg = 2048;
        height_reg = 4096;
        restart_frame();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(0, 0, 120);
        test_random(78, 0, 120);
        test_random(0, 78, 120);
        test_random(8, 8, 120);
        test_backpressure();
        test_extremes();
        drain();

        $display("covered %0d words (%0d pixels, %0d flushes), %0d complete frames,",
                 n_words, n_pixels, n_flushes, n_frames);
        $display("%0d filtered words checked under idle, stall and held back-pressure",
                 n_results);
        if (n_errors == 0 && pending_pix.size() == 0)
            $display("rgb_kernel_convolution verification clean");
        else
            $display("rgb_kernel_convolution verification failed");
        $finish;
    end

endmodule
